@@ rtl/core/tlmt_pkg.sv @@
// Package for the track link multiplexer with stub truncation.
// Holds field widths, register indexes, error codes and the eta modulo-three table.
// No dependencies.
package tlmt_pkg;

    localparam int MAX_LINKS = 256;
    localparam int LINK_AW   = $clog2(MAX_LINKS);
    localparam int TOTAL_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MUX_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STUB_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_REGIONS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MBIN_RANGES = 3'd5;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_ETA   = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    localparam logic [5:0] DEMO_ETA_REGIONS = 6'd18;

    typedef logic [1:0] t_mod3_tab [32];

    localparam t_mod3_tab ETA_MOD3 = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
    };

endpackage

@@ rtl/core/tlmt_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module tlmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/track_link_mux_truncation.sv @@
// Track link multiplexer with per-link stub counting and truncation.
// An accepted beat is registered in the B stage, then in the output register. One beat
// is taken every cycle unless the output stalls; the link total read and write-back
// with forwarding sets this. Reset is synchronous and active low; it restores the register
// defaults and clears every link valid bit at once. Depends on tlmt_pkg and tlmt_ram.
module track_link_mux_truncation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlmt_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_octant_start,
    input  logic [2:0]                      i_sector_in_octant,
    input  logic [4:0]                      i_eta_region,
    input  logic [2:0]                      i_mbin_range,
    input  logic [5:0]                      i_stub_count,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_link_id,
    output logic                            o_keep,
    output logic [1:0]                      o_error_code
);

    import tlmt_pkg::*;

    logic                 r_mux_mode;
    logic                 r_kill_enable;
    logic [TOTAL_W-1:0]   r_stub_limit;
    logic [3:0]           r_spo;
    logic [5:0]           r_eta_regions;
    logic [3:0]           r_mbin_ranges;

    logic                 in_acc;
    logic                 b_adv;
    logic [6:0]           sec_mbin;
    logic [8:0]           link_calc;
    logic [7:0]           lpo_base;
    logic [9:0]           lpo;
    logic [1:0]           n_err;
    logic [LINK_AW-1:0]   n_link;

    logic                 r_b_vld;
    logic                 r_b_start;
    logic [LINK_AW-1:0]   r_b_link;
    logic [1:0]           r_b_err;
    logic [5:0]           r_b_stubs;

    logic [MAX_LINKS-1:0] r_lvld;
    logic                 r_fwd_vld;
    logic [LINK_AW-1:0]   r_fwd_link;
    logic [TOTAL_W-1:0]   r_fwd_total;

    logic [TOTAL_W-1:0]   ram_q;
    logic [TOTAL_W-1:0]   base;
    logic [TOTAL_W:0]     sum;
    logic [TOTAL_W-1:0]   n_total;
    logic                 n_keep;
    logic                 b_write;

    logic                 r_o_vld;
    logic [7:0]           r_o_link;
    logic                 r_o_keep;
    logic [1:0]           r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux_mode    <= 1'b1;
            r_kill_enable <= 1'b1;
            r_stub_limit  <= 16'd210;
            r_spo         <= 4'd4;
            r_eta_regions <= 6'd18;
            r_mbin_ranges <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MUX_MODE:    r_mux_mode    <= i_cfg_data[0];
                REG_KILL_ENABLE: r_kill_enable <= i_cfg_data[0];
                REG_STUB_LIMIT:  r_stub_limit  <= i_cfg_data[TOTAL_W-1:0];
                REG_SECTORS:     r_spo         <= i_cfg_data[3:0];
                REG_ETA_REGIONS: r_eta_regions <= i_cfg_data[5:0];
                REG_MBIN_RANGES: r_mbin_ranges <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign b_adv      = r_b_vld && (!r_o_vld || !i_out_stall);
    assign o_in_stall = r_b_vld && !b_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        sec_mbin = {3'b000, r_spo} * {4'b0000, i_mbin_range};
        lpo_base = {4'b0000, r_spo} * {4'b0000, r_mbin_ranges};
        if (!r_mux_mode) begin
            link_calc = {7'b0, ETA_MOD3[i_eta_region]} + 9'd3 * {6'b0, i_sector_in_octant}
                        + 9'd3 * {2'b00, sec_mbin};
            lpo       = 10'd3 * {2'b00, lpo_base};
        end else begin
            link_calc = {6'b0, i_sector_in_octant} + {2'b00, sec_mbin};
            lpo       = {2'b00, lpo_base};
        end
        n_link = '0;
        if (!r_mux_mode && r_eta_regions != DEMO_ETA_REGIONS) begin
            n_err = ERR_ETA;
        end else if ({1'b0, link_calc} >= lpo || int'(link_calc) >= MAX_LINKS) begin
            n_err = ERR_RANGE;
        end else begin
            n_err  = ERR_OK;
            n_link = link_calc[LINK_AW-1:0];
        end
    end

    tlmt_ram #(
        .WIDTH(TOTAL_W),
        .DEPTH(MAX_LINKS)
    ) u_total_ram (
        .i_clk  (i_clk),
        .i_we   (b_write),
        .i_waddr(r_b_link),
        .i_wdata(n_total),
        .i_re   (in_acc),
        .i_raddr(n_link),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (in_acc) begin
            r_b_vld <= 1'b1;
        end else if (b_adv) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_start <= i_octant_start;
            r_b_link  <= n_link;
            r_b_err   <= n_err;
            r_b_stubs <= i_stub_count;
        end
    end

    always_comb begin
        if (r_b_start) begin
            base = '0;
        end else if (r_fwd_vld && r_fwd_link == r_b_link) begin
            base = r_fwd_total;
        end else if (r_lvld[r_b_link]) begin
            base = ram_q;
        end else begin
            base = '0;
        end
        sum     = {1'b0, base} + {{(TOTAL_W-5){1'b0}}, r_b_stubs};
        n_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        n_keep  = (r_b_err == ERR_OK) && (!r_kill_enable || n_total <= r_stub_limit);
        b_write = b_adv && (r_b_err == ERR_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld    <= '0;
            r_fwd_vld <= 1'b0;
        end else if (in_acc && i_octant_start) begin
            r_lvld    <= '0;
            r_fwd_vld <= 1'b0;
        end else if (b_write) begin
            r_lvld[r_b_link] <= 1'b1;
            r_fwd_vld        <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_write) begin
            r_fwd_link  <= r_b_link;
            r_fwd_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_adv) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_o_link <= 8'(r_b_link);
            r_o_keep <= n_keep;
            r_o_err  <= r_b_err;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_link_id    = r_o_link;
    assign o_keep       = r_o_keep;
    assign o_error_code = r_o_err;

    a_err_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != ERR_OK) |-> (!o_keep && o_link_id == 8'd0))
        else $error("Erroring beat carries a link or keep flag.");

    a_fwd_marked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_vld |-> r_lvld[r_fwd_link])
        else $error("Forwarded total points at a link without a valid total.");

    a_octant_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_octant_start) |=> (r_lvld == '0 && !r_fwd_vld))
        else $error("Link totals not cleared at octant start.");

    a_write_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_write |-> (r_b_vld && r_b_err == ERR_OK))
        else $error("Total written for an empty or erroring stage.");

endmodule

@@ tb/sv/track_link_mux_truncation_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for track_link_mux_truncation: directed and random track beats,
// checked against a link-total predictor kept in the bench, under random idling.
// Depends on tlmt_pkg and the RTL of the block.
module track_link_mux_truncation_tb;
    import tlmt_pkg::*;

    localparam int PIPE_LATENCY    = 2;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 120;

    typedef struct packed {
        logic       start;
        logic [2:0] sector;
        logic [4:0] eta;
        logic [2:0] mbin;
        logic [5:0] stubs;
    } t_track;

    typedef struct packed {
        logic [7:0] link;
        logic       keep;
        logic [1:0] err;
    } t_link_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_octant_start;
    logic [2:0]           i_sector_in_octant;
    logic [4:0]           i_eta_region;
    logic [2:0]           i_mbin_range;
    logic [5:0]           i_stub_count;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [7:0]           o_link_id;
    logic                 o_keep;
    logic [1:0]           o_error_code;

    logic [TOTAL_W-1:0] link_total [MAX_LINKS];
    logic               cfg_mode;
    logic               cfg_kill;
    logic [15:0]        cfg_limit;
    logic [3:0]         cfg_spo;
    logic [5:0]         cfg_eta;
    logic [3:0]         cfg_mbins;

    t_link_res expected_q [$];
    t_link_res due_res;
    int        mismatches   = 0;
    int        gap_pct      = 11;
    int        stall_pct    = 11;
    int        quiet_cycles = 0;
    int        hold_left    = 0;
    logic      hold_request = 1'b0;

    track_link_mux_truncation u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_octant_start     (i_octant_start),
        .i_sector_in_octant (i_sector_in_octant),
        .i_eta_region       (i_eta_region),
        .i_mbin_range       (i_mbin_range),
        .i_stub_count       (i_stub_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_link_id          (o_link_id),
        .o_keep             (o_keep),
        .o_error_code       (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_link_res route_track(t_track t);
        int        link;
        int        nlinks;
        int        total;
        t_link_res r;
        r = '{link: 8'd0, keep: 1'b0, err: ERR_OK};
        if (t.start) begin
            for (int i = 0; i < MAX_LINKS; i++) link_total[i] = '0;
        end
        if (!cfg_mode && cfg_eta != DEMO_ETA_REGIONS) begin
            r.err = ERR_ETA;
            return r;
        end
        nlinks = int'(cfg_spo) * int'(cfg_mbins);
        if (!cfg_mode) begin
            link   = int'(t.eta) % 3 + 3 * int'(t.sector) + 3 * int'(cfg_spo) * int'(t.mbin);
            nlinks = 3 * nlinks;
        end else begin
            link = int'(t.sector) + int'(cfg_spo) * int'(t.mbin);
        end
        if (link >= nlinks || link >= MAX_LINKS || link > 255) begin
            r.err = ERR_RANGE;
            return r;
        end
        total = int'(link_total[link]) + int'(t.stubs);
        if (total > 65535) total = 65535;
        link_total[link] = total[15:0];
        r.link = link[7:0];
        r.keep = !cfg_kill || total <= int'(cfg_limit);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            REG_MUX_MODE:    cfg_mode  = data[0];
            REG_KILL_ENABLE: cfg_kill  = data[0];
            REG_STUB_LIMIT:  cfg_limit = data[15:0];
            REG_SECTORS:     cfg_spo   = data[3:0];
            REG_ETA_REGIONS: cfg_eta   = data[5:0];
            REG_MBIN_RANGES: cfg_mbins = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic send_track(input t_track t);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? 1 : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid         = 1'b1;
        i_octant_start     = t.start;
        i_sector_in_octant = t.sector;
        i_eta_region       = t.eta;
        i_mbin_range       = t.mbin;
        i_stub_count       = t.stubs;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.insert(expected_q.size(), route_track(t));
    endtask

    // Sends one octant: sectors ascend and eta ascends within a sector, with some noise beats.
    task automatic send_octant(input int n);
        int     hi_sec;
        int     hi_eta;
        int     hi_mb;
        int     sec;
        int     eta;
        t_track t;
        hi_sec = (cfg_spo >= 1 && cfg_spo <= 8) ? int'(cfg_spo) - 1 : 7;
        hi_eta = (cfg_eta >= 1 && cfg_eta <= 32) ? int'(cfg_eta) - 1 : 31;
        hi_mb  = (cfg_mbins >= 1 && cfg_mbins <= 8) ? int'(cfg_mbins) - 1 : 7;
        sec = 0;
        eta = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 10) begin
                t = 18'($urandom);
            end else begin
                if ($urandom_range(99) < 30 && sec < hi_sec) begin
                    sec++;
                    eta = 0;
                end else begin
                    eta = eta + int'($urandom_range(0, 3));
                    if (eta > hi_eta) eta = hi_eta;
                end
                t.start  = 1'b0;
                t.sector = 3'(sec);
                t.eta    = 5'(eta);
                t.mbin   = 3'($urandom_range(0, hi_mb));
                t.stubs  = 6'($urandom_range(0, 63));
            end
            if (k == 0) t.start = 1'b1;
            send_track(t);
        end
    endtask

    task automatic randomize_config();
        int lim;
        int spo;
        int mb;
        int eta;
        write_reg(REG_MUX_MODE, {15'($urandom), 1'($urandom_range(0, 1))});
        write_reg(REG_KILL_ENABLE, {15'($urandom), 1'($urandom_range(99) < 75)});
        case ($urandom_range(0, 9))
            0:       lim = 0;
            1:       lim = 65535;
            default: lim = $urandom_range(0, 300);
        endcase
        write_reg(REG_STUB_LIMIT, 16'(lim));
        spo = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(0, 15);
        mb  = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(0, 15);
        write_reg(REG_SECTORS, {12'($urandom), 4'(spo)});
        write_reg(REG_MBIN_RANGES, {12'($urandom), 4'(mb)});
        eta = (!cfg_mode && $urandom_range(99) < 85) ? 18 : $urandom_range(0, 63);
        write_reg(REG_ETA_REGIONS, {10'($urandom), 6'(eta)});
    endtask

    task automatic test_default_config();
        drain_pipe();
        send_track('{1'b1, 3'd0, 5'd0, 3'd0, 6'd63});
        send_track('{1'b0, 3'd0, 5'd31, 3'd0, 6'd63});
        send_track('{1'b0, 3'd0, 5'd0, 3'd0, 6'd63});
        send_track('{1'b0, 3'd0, 5'd5, 3'd0, 6'd21});
        send_track('{1'b0, 3'd0, 5'd6, 3'd0, 6'd1});
        send_track('{1'b0, 3'd7, 5'd0, 3'd0, 6'd5});
        send_track('{1'b0, 3'd4, 5'd0, 3'd1, 6'd0});
        send_track('{1'b1, 3'd7, 5'd31, 3'd7, 6'd63});
        send_track('{1'b0, 3'd0, 5'd0, 3'd0, 6'd0});
        drain_pipe();
    endtask

    task automatic test_demo_mux();
        drain_pipe();
        write_reg(REG_MUX_MODE, 16'h0000);
        send_track('{1'b1, 3'd0, 5'd0, 3'd0, 6'd10});
        send_track('{1'b0, 3'd0, 5'd31, 3'd0, 6'd10});
        send_track('{1'b0, 3'd3, 5'd29, 3'd1, 6'd63});
        send_track('{1'b0, 3'd7, 5'd0, 3'd1, 6'd1});
        drain_pipe();
        write_reg(REG_ETA_REGIONS, 16'd17);
        send_track('{1'b1, 3'd3, 5'd29, 3'd1, 6'd5});
        drain_pipe();
        write_reg(REG_ETA_REGIONS, 16'd18);
        write_reg(REG_KILL_ENABLE, 16'h0000);
        repeat (4) send_track('{1'b0, 3'd3, 5'd29, 3'd1, 6'd63});
        drain_pipe();
    endtask

    task automatic test_link_range();
        drain_pipe();
        write_reg(REG_MUX_MODE, 16'hFFFE);
        write_reg(REG_KILL_ENABLE, 16'hFFFF);
        write_reg(REG_STUB_LIMIT, 16'h0000);
        write_reg(REG_SECTORS, 16'hFFFF);
        write_reg(REG_MBIN_RANGES, 16'hFFFF);
        write_reg(REG_ETA_REGIONS, 16'hFFD2);
        send_track('{1'b1, 3'd7, 5'd2, 3'd7, 6'd1});
        send_track('{1'b0, 3'd0, 5'd0, 3'd5, 6'd0});
        send_track('{1'b0, 3'd7, 5'd2, 3'd5, 6'd1});
        send_track('{1'b0, 3'd7, 5'd2, 3'd6, 6'd0});
        drain_pipe();
        write_reg(REG_SECTORS, 16'h0000);
        send_track('{1'b0, 3'd0, 5'd0, 3'd0, 6'd0});
        drain_pipe();
    endtask

    task automatic test_output_hold_off();
        drain_pipe();
        write_reg(REG_MUX_MODE, 16'd1);
        write_reg(REG_KILL_ENABLE, 16'd1);
        write_reg(REG_STUB_LIMIT, 16'd100);
        write_reg(REG_SECTORS, 16'd8);
        write_reg(REG_MBIN_RANGES, 16'd8);
        gap_pct      = 0;
        hold_request = 1'b1;
        send_octant(40);
        gap_pct = 11;
        drain_pipe();
    endtask

    task automatic test_total_saturation();
        int     k;
        t_track t;
        drain_pipe();
        write_reg(REG_MUX_MODE, 16'd1);
        write_reg(REG_KILL_ENABLE, 16'd1);
        write_reg(REG_STUB_LIMIT, 16'($urandom_range(64000, 65534)));
        write_reg(REG_SECTORS, 16'd1);
        write_reg(REG_MBIN_RANGES, 16'd1);
        gap_pct   = 0;
        stall_pct = 0;
        k = 0;
        while (link_total[0] != 16'hFFFF || k < 1060) begin
            if (k == 300) begin
                gap_pct   = 11;
                stall_pct = 11;
            end
            if (k > 0 && $urandom_range(99) < 3) begin
                t       = 18'($urandom);
                t.start = 1'b0;
            end else begin
                t = '{(k == 0), 3'd0, 5'($urandom), 3'd0, 6'd63};
            end
            send_track(t);
            k++;
        end
        drain_pipe();
    endtask

    task automatic test_random_octants();
        int sent;
        int n;
        repeat (2) begin
            drain_pipe();
            randomize_config();
            sent = 0;
            while (sent < 40) begin
                n = $urandom_range(3, 20);
                send_octant(n);
                sent += n;
            end
        end
        drain_pipe();
    endtask

    initial begin
        logic hold_armed;
        hold_armed  = 1'b1;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat: link %0d keep %0b error %0d",
                         $time, o_link_id, o_keep, o_error_code);
            end else begin
                due_res = expected_q.pop_front();
                if (o_link_id !== due_res.link || o_keep !== due_res.keep
                        || o_error_code !== due_res.err) begin
                    mismatches++;
                    $display("%0t: mismatch: expected link %0d keep %0b error %0d, got %0d %0b %0d",
                             $time, due_res.link, due_res.keep, due_res.err,
                             o_link_id, o_keep, o_error_code);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL track_link_mux_truncation");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = REG_MUX_MODE;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_octant_start     = 1'b0;
        i_sector_in_octant = '0;
        i_eta_region       = '0;
        i_mbin_range       = '0;
        i_stub_count       = '0;
        cfg_mode           = 1'b1;
        cfg_kill           = 1'b1;
        cfg_limit          = 16'd210;
        cfg_spo            = 4'd4;
        cfg_eta            = 6'd18;
        cfg_mbins          = 4'd2;
        for (int i = 0; i < MAX_LINKS; i++) link_total[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_config();
        test_demo_mux();
        test_link_range();
        test_output_hold_off();
        test_total_saturation();
        test_random_octants();

        if (mismatches == 0) begin
            $display("PASS track_link_mux_truncation");
        end else begin
            $display("FAIL track_link_mux_truncation");
        end
        $finish;
    end

endmodule
